// ----- rtl/pf_pkg.sv -----
// ============================================================================
// pf_pkg: shared types and constants of the Playfair pair cipher
// Letter codes, square geometry, request and status codes, and the
// command and status bundles between controller and datapath.
// ============================================================================
package pf_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned CELL_W   = 5;
    localparam int unsigned NUM_LETTERS = 26;
    localparam int unsigned SQ_CELLS_N  = 25;

    localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;
    localparam logic [CELL_W-1:0]   SQ_CELLS    = 5'd25;
    localparam logic [2:0]          SQ_LAST     = 3'd4;

    typedef enum logic [1:0] {
        REQ_KEY    = 2'd0,
        REQ_FINISH = 2'd1,
        REQ_PAIR   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUP       = 2'd1,
        ST_NOT_READY = 2'd2
    } t_stat;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_KEY,
        RES_PAIR
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      key_place;
        logic      fill_step;
        logic      set_ready;
        logic      pos_sel_b;
        logic      capture_pa;
        logic      calc;
        logic      sq_sel_2;
        logic      capture_o1;
        logic      res_we;
        t_res_kind res_kind;
    } t_pf_cmd;

    typedef struct packed {
        logic ready;
        logic fill_last;
    } t_pf_sts;

endpackage

// ----- rtl/pf_ram.sv -----
// ============================================================================
// pf_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ============================================================================
module pf_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pf_ctrl.sv -----
// ============================================================================
// pf_ctrl: sequencer of the Playfair pair cipher
// Walks key placement, square fill and the pair lookup steps, and raises
// the result strobe.
// ============================================================================
module pf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_req_type,
    input  pf_pkg::t_pf_sts  i_sts,
    output pf_pkg::t_pf_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import pf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY,
        S_FILL,
        S_POS_A,
        S_POS_B,
        S_CALC,
        S_SQ_1,
        S_SQ_2,
        S_SQ_3,
        S_PLAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.res_kind = RES_PLAIN;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_KEY:    n_state = S_KEY;
                        REQ_FINISH: n_state = S_FILL;
                        REQ_PAIR:   n_state = i_sts.ready ? S_POS_A : S_PLAIN;
                        default:    n_state = S_PLAIN;
                    endcase
                end
            end
            S_KEY: begin
                o_cmd.key_place = 1'b1;
                o_cmd.res_we    = 1'b1;
                o_cmd.res_kind  = RES_KEY;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.set_ready = 1'b1;
                    o_cmd.res_we    = 1'b1;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_POS_A: begin
                n_state = S_POS_B;
            end
            S_POS_B: begin
                o_cmd.pos_sel_b  = 1'b1;
                o_cmd.capture_pa = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_SQ_1;
            end
            S_SQ_1: begin
                n_state = S_SQ_2;
            end
            S_SQ_2: begin
                o_cmd.sq_sel_2   = 1'b1;
                o_cmd.capture_o1 = 1'b1;
                n_state = S_SQ_3;
            end
            S_SQ_3: begin
                o_cmd.res_we   = 1'b1;
                o_cmd.res_kind = RES_PAIR;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_PLAIN: begin
                o_cmd.res_we = 1'b1;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ----- rtl/pf_dpath.sv -----
// ============================================================================
// pf_dpath: datapath of the Playfair pair cipher
// Holds the square and letter position memories, the placement state,
// the mode register and the result registers.
// ============================================================================
module pf_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pf_pkg::t_pf_cmd                 i_cmd,
    output pf_pkg::t_pf_sts                 o_sts,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data,
    input  logic [1:0]                      i_req_type,
    input  logic [pf_pkg::LETTER_W-1:0]     i_letter_first,
    input  logic [pf_pkg::LETTER_W-1:0]     i_letter_second,
    output logic [pf_pkg::LETTER_W-1:0]     o_out_first,
    output logic [pf_pkg::LETTER_W-1:0]     o_out_second,
    output logic [1:0]                      o_status
);
    import pf_pkg::*;

    // saturate above 'z', then fold j onto i
    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] raw);
        logic [LETTER_W-1:0] v;
        v = (raw > LETTER_LAST) ? LETTER_LAST : raw;
        if (v == LETTER_J) begin
            v = LETTER_I;
        end
        return v;
    endfunction

    function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] p);
        logic [2:0] r;
        if (p < 5'd5) begin
            r = 3'd0;
        end else if (p < 5'd10) begin
            r = 3'd1;
        end else if (p < 5'd15) begin
            r = 3'd2;
        end else if (p < 5'd20) begin
            r = 3'd3;
        end else begin
            r = 3'd4;
        end
        return r;
    endfunction

    function automatic logic [2:0] cell_col(input logic [CELL_W-1:0] p, input logic [2:0] r);
        logic [CELL_W-1:0] base;
        logic [CELL_W-1:0] diff;
        base = {r, 2'b00} + {2'b00, r};
        diff = p - base;
        return diff[2:0];
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    // one step along a row or column, wrapping
    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
        logic [2:0] n;
        if (dec) begin
            n = (v == 3'd0) ? SQ_LAST : v - 3'd1;
        end else begin
            n = (v == SQ_LAST) ? 3'd0 : v + 3'd1;
        end
        return n;
    endfunction

    logic                   r_decrypt;
    logic [NUM_LETTERS-1:0] r_placed;
    logic [CELL_W-1:0]      r_fill;
    logic                   r_ready;
    t_req                   r_req;
    logic [LETTER_W-1:0]    r_a, r_b, r_k;
    logic [CELL_W-1:0]      r_pa, r_x1, r_x2;
    logic [LETTER_W-1:0]    r_o1;
    logic [LETTER_W-1:0]    r_out_first, r_out_second;
    t_stat                  r_status;

    logic                   can_a, can_k, we;
    logic [LETTER_W-1:0]    wletter;
    logic [CELL_W-1:0]      pos_rdata;
    logic [LETTER_W-1:0]    sq_rdata;
    logic [2:0]             r1, c1, r2, c2;
    logic [CELL_W-1:0]      n_x1, n_x2;

    // placement decisions for a key letter and a fill letter
    assign can_a   = !r_placed[r_a] && (r_fill < SQ_CELLS);
    assign can_k   = (r_k != LETTER_J) && !r_placed[r_k] && (r_fill < SQ_CELLS);
    assign we      = (i_cmd.key_place && can_a) || (i_cmd.fill_step && can_k);
    assign wletter = i_cmd.key_place ? r_a : r_k;

    pf_ram #(
        .WIDTH(LETTER_W),
        .DEPTH(SQ_CELLS_N)
    ) u_square (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_fill),
        .i_wdata(wletter),
        .i_raddr(i_cmd.sq_sel_2 ? r_x2 : r_x1),
        .o_rdata(sq_rdata)
    );

    pf_ram #(
        .WIDTH(CELL_W),
        .DEPTH(NUM_LETTERS)
    ) u_position (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(wletter),
        .i_wdata(r_fill),
        .i_raddr(i_cmd.pos_sel_b ? r_b : r_a),
        .o_rdata(pos_rdata)
    );

    // substitute cell indices from the two positions
    always_comb begin
        r1 = cell_row(r_pa);
        c1 = cell_col(r_pa, r1);
        r2 = cell_row(pos_rdata);
        c2 = cell_col(pos_rdata, r2);
        if (r1 == r2) begin
            n_x1 = cell_index(r1, wrap_step(c1, r_decrypt));
            n_x2 = cell_index(r2, wrap_step(c2, r_decrypt));
        end else if (c1 == c2) begin
            n_x1 = cell_index(wrap_step(r1, r_decrypt), c1);
            n_x2 = cell_index(wrap_step(r2, r_decrypt), c2);
        end else begin
            n_x1 = cell_index(r1, c2);
            n_x2 = cell_index(r2, c1);
        end
    end

    // control state: mode, placed letters, fill count, ready flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_placed  <= '0;
            r_fill    <= '0;
            r_ready   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_decrypt <= i_cfg_data;
            end
            if (we) begin
                r_placed[wletter] <= 1'b1;
                r_fill            <= r_fill + 5'd1;
            end
            if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
        end
    end

    // item latches, lookup pipeline and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_req_type);
            r_a   <= fold_letter(i_letter_first);
            r_b   <= fold_letter(i_letter_second);
            r_k   <= '0;
        end else if (i_cmd.fill_step) begin
            r_k <= r_k + 5'd1;
        end
        if (i_cmd.capture_pa) begin
            r_pa <= pos_rdata;
        end
        if (i_cmd.calc) begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
        end
        if (i_cmd.capture_o1) begin
            r_o1 <= sq_rdata;
        end
        if (i_cmd.res_we) begin
            case (i_cmd.res_kind)
                RES_KEY: begin
                    r_out_first  <= '0;
                    r_out_second <= '0;
                    r_status     <= can_a ? ST_OK : ST_DUP;
                end
                RES_PAIR: begin
                    r_out_first  <= r_o1;
                    r_out_second <= sq_rdata;
                    r_status     <= ST_OK;
                end
                default: begin
                    r_out_first  <= '0;
                    r_out_second <= '0;
                    r_status     <= (r_req == REQ_PAIR) ? ST_NOT_READY : ST_OK;
                end
            endcase
        end
    end

    assign o_sts.ready     = r_ready;
    assign o_sts.fill_last = (r_k == LETTER_LAST);
    assign o_out_first     = r_out_first;
    assign o_out_second    = r_out_second;
    assign o_status        = r_status;

endmodule

// ----- rtl/playfair_pair_cipher.sv -----
// ============================================================================
// playfair_pair_cipher: 5x5 Playfair square builder and pair substitution
// Builds the square from key letters, then enciphers or deciphers pairs.
// ============================================================================
// Usage:
//   Request channel: an item is taken at a clock edge with start high and
//   busy low. i_req_type selects key letter, finish, or letter pair.
//   Result channel: o_done is high for one cycle with o_out_first,
//   o_out_second and o_status; the receiver takes it in that cycle and
//   cannot hold it off.
//   Mode channel: i_cfg_valid/o_cfg_ready write i_cfg_data into the
//   decrypt mode bit; write it only while no item is in flight.
// Sequence, from the accepting edge to the result:
//   key letter: S_KEY; unknown request, pair before finish: S_PLAIN
//   letter pair: S_POS_A to S_SQ_3 (two reads of the position memory, one
//   index calculation, two reads of the square memory, all on single read
//   ports); finish: S_FILL (one letter of the alphabet tried per cycle)
//   The next item may be accepted in the cycle the result is shown; busy
//   stays high until then, so no item is taken while one is in flight.
// Reset clears the mode bit, placed letters, fill count and ready flag;
// the square and position memories are left as they are and only read
// once the square is finished.
// ============================================================================
module playfair_pair_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [pf_pkg::LETTER_W-1:0] i_letter_first,
    input  logic [pf_pkg::LETTER_W-1:0] i_letter_second,
    output logic                        o_done,
    output logic [pf_pkg::LETTER_W-1:0] o_out_first,
    output logic [pf_pkg::LETTER_W-1:0] o_out_second,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);
    import pf_pkg::*;

    t_pf_cmd cmd;
    t_pf_sts sts;

    // mode writes are always taken
    assign o_cfg_ready = 1'b1;

    pf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req_type(i_req_type),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    pf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_letter_first (i_letter_first),
        .i_letter_second(i_letter_second),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_status       (o_status)
    );

    // a result beat always lands back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // every accepted item raises busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // a result never carries an undefined status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status != 2'd3))
        else $error("undefined status code");

    // an unfinished square gives zero letters
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NOT_READY)) |->
            ((o_out_first == '0) && (o_out_second == '0)))
        else $error("letters on a not-ready result");

endmodule

// ----- verif/tb_playfair_pair_cipher.sv -----
// ============================================================================
// tb_playfair_pair_cipher: self-checking bench for the Playfair pair cipher
// Builds one square from directed and random key letters, finishes it, then
// drives letter pairs in both modes with random gaps on the request side.
// A local model predicts every result and the monitor checks them in order.
// ============================================================================
module tb_playfair_pair_cipher;

    import pf_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SQ_SIDE       = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SHOWN_ERRORS  = 10;

    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_MODE,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind        kind;
        t_req             req;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic             mode;
    } t_cipher_job;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        t_stat               status;
    } t_cipher_out;

    // DUT connections, known from time zero
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic [1:0]          i_req_type      = 2'd0;
    logic [LETTER_W-1:0] i_letter_first  = '0;
    logic [LETTER_W-1:0] i_letter_second = '0;
    logic                o_done;
    logic [LETTER_W-1:0] o_out_first;
    logic [LETTER_W-1:0] o_out_second;
    logic [1:0]          o_status;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data      = 1'b0;

    // Square model
    logic [LETTER_W-1:0] sq_cell [SQ_CELLS_N];
    logic [CELL_W-1:0]   cell_of [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] placed = '0;
    int                  fill_cnt    = 0;
    bit                  square_done = 1'b0;
    bit                  decipher    = 1'b0;

    t_cipher_job         job_queue[$];
    t_cipher_out         cipher_results_due[$];
    logic                req_taken    = 1'b0;
    logic                cfg_taken    = 1'b0;
    int                  error_count  = 0;
    int                  gap_left     = 0;
    int                  calm_left    = 0;
    int                  quiet_cycles = 0;

    playfair_pair_cipher u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_letter_first (i_letter_first),
        .i_letter_second(i_letter_second),
        .o_done         (o_done),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Square model
    // ------------------------------------------------------------------
    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] raw);
        logic [LETTER_W-1:0] v;
        v = (raw > LETTER_LAST) ? LETTER_LAST : raw;
        if (v == LETTER_J) begin
            v = LETTER_I;
        end
        return v;
    endfunction

    function automatic bit claim_cell(input logic [LETTER_W-1:0] letter);
        if (fill_cnt >= SQ_CELLS_N || placed[letter]) begin
            return 1'b0;
        end
        sq_cell[fill_cnt] = letter;
        cell_of[letter]   = CELL_W'(fill_cnt);
        placed[letter]    = 1'b1;
        fill_cnt++;
        return 1'b1;
    endfunction

    function automatic t_cipher_out playfair_predict(input logic [1:0] req,
                                                     input logic [LETTER_W-1:0] raw_a,
                                                     input logic [LETTER_W-1:0] raw_b);
        t_cipher_out         res;
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
        int                  p1, p2, r1, c1, r2, c2, shift;
        res = '{first: '0, second: '0, status: ST_OK};
        a = fold_letter(raw_a);
        b = fold_letter(raw_b);
        case (t_req'(req))
            REQ_KEY: begin
                if (!claim_cell(a)) begin
                    res.status = ST_DUP;
                end
            end
            REQ_FINISH: begin
                for (int k = 0; k < NUM_LETTERS; k++) begin
                    if (k != LETTER_J) begin
                        void'(claim_cell(LETTER_W'(k)));
                    end
                end
                square_done = 1'b1;
            end
            REQ_PAIR: begin
                if (!square_done) begin
                    res.status = ST_NOT_READY;
                end else begin
                    p1 = cell_of[a] % SQ_CELLS_N;
                    p2 = cell_of[b] % SQ_CELLS_N;
                    r1 = p1 / SQ_SIDE;
                    c1 = p1 % SQ_SIDE;
                    r2 = p2 / SQ_SIDE;
                    c2 = p2 % SQ_SIDE;
                    shift = decipher ? SQ_SIDE - 1 : 1;
                    if (r1 == r2) begin
                        res.first  = sq_cell[r1*SQ_SIDE + (c1 + shift) % SQ_SIDE];
                        res.second = sq_cell[r2*SQ_SIDE + (c2 + shift) % SQ_SIDE];
                    end else if (c1 == c2) begin
                        res.first  = sq_cell[((r1 + shift) % SQ_SIDE)*SQ_SIDE + c1];
                        res.second = sq_cell[((r2 + shift) % SQ_SIDE)*SQ_SIDE + c2];
                    end else begin
                        res.first  = sq_cell[r1*SQ_SIDE + c2];
                        res.second = sq_cell[r2*SQ_SIDE + c1];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(input t_req req, input logic [LETTER_W-1:0] a,
                                      input logic [LETTER_W-1:0] b);
        job_queue.push_back('{kind: JOB_ITEM, req: req, first: a, second: b, mode: 1'b0});
    endfunction

    function automatic void push_mode(input logic mode);
        job_queue.push_back('{kind: JOB_MODE, req: REQ_NONE, first: '0, second: '0,
                              mode: mode});
    endfunction

    function automatic void push_drain();
        job_queue.push_back('{kind: JOB_DRAIN, req: REQ_NONE, first: '0, second: '0,
                              mode: 1'b0});
    endfunction

    function automatic logic [LETTER_W-1:0] any_letter();
        return LETTER_W'($urandom_range(0, 31));
    endfunction

    // Spell a letter another way that folds back to it (j for i, 26..31 for z)
    function automatic logic [LETTER_W-1:0] respell(input logic [LETTER_W-1:0] letter);
        if (letter == LETTER_I && $urandom_range(0, 1) == 1) begin
            return LETTER_J;
        end
        if (letter == LETTER_LAST && $urandom_range(0, 2) == 0) begin
            return LETTER_W'($urandom_range(26, 31));
        end
        return letter;
    endfunction

    function automatic void push_cells(input int p1, input int p2);
        push_item(REQ_PAIR, respell(sq_cell[p1]), respell(sq_cell[p2]));
    endfunction

    // Pair aimed at a row, a column, a single cell or a rectangle
    function automatic void push_aimed_pair();
        int p1, p2, pick;
        p1   = $urandom_range(0, SQ_CELLS_N - 1);
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            p2 = (p1 / SQ_SIDE) * SQ_SIDE + $urandom_range(0, SQ_SIDE - 1);
        end else if (pick < 6) begin
            p2 = $urandom_range(0, SQ_SIDE - 1) * SQ_SIDE + p1 % SQ_SIDE;
        end else if (pick == 6) begin
            p2 = p1;
        end else begin
            p2 = $urandom_range(0, SQ_CELLS_N - 1);
        end
        push_cells(p1, p2);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic wait_settled();
        do @(posedge i_clk);
        while (job_queue.size() != 0 || start || i_cfg_valid ||
               cipher_results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: launch one beat at a time, hold mode writes until drained
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_proc
        logic        next_start;
        logic        next_cfg;
        t_cipher_job job;
        next_start = start && !req_taken;
        next_cfg   = i_cfg_valid && !cfg_taken;
        if (!i_rst_n) begin
            next_start = 1'b0;
            next_cfg   = 1'b0;
        end else if (!next_start && !next_cfg) begin
            if (cipher_results_due.size() == 0) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (job_queue.size() > 0) begin
                job = job_queue[0];
                if (job.kind == JOB_ITEM) begin
                    void'(job_queue.pop_front());
                    i_req_type      <= job.req;
                    i_letter_first  <= job.first;
                    i_letter_second <= job.second;
                    next_start      = 1'b1;
                    gap_left        = pick_gap();
                end else if (quiet_cycles >= SETTLE_CYCLES) begin
                    void'(job_queue.pop_front());
                    if (job.kind == JOB_MODE) begin
                        i_cfg_data <= job.mode;
                        next_cfg   = 1'b1;
                    end
                    quiet_cycles = 0;
                end
            end
        end
        start       <= next_start;
        i_cfg_valid <= next_cfg;
    end

    // ------------------------------------------------------------------
    // Monitor: check results in order, predict each accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_proc
        t_cipher_out want;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            cfg_taken   <= 1'b0;
            placed      = '0;
            fill_cnt    = 0;
            square_done = 1'b0;
            decipher    = 1'b0;
        end else begin
            req_taken <= start && !busy;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (o_done) begin
                if (cipher_results_due.size() == 0) begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS) begin
                        $display("unexpected result at %0t: first %0d second %0d status %0d",
                                 $time, o_out_first, o_out_second, o_status);
                    end
                end else begin
                    want = cipher_results_due.pop_front();
                    if (o_out_first !== want.first || o_out_second !== want.second ||
                        o_status !== want.status) begin
                        error_count++;
                        if (error_count <= SHOWN_ERRORS) begin
                            $display({"mismatch at %0t: first exp %0d got %0d, ",
                                      "second exp %0d got %0d, status exp %0d got %0d"},
                                     $time, want.first, o_out_first, want.second,
                                     o_out_second, want.status, o_status);
                        end
                    end
                end
            end
            if (start && !busy) begin
                cipher_results_due.push_back(
                    playfair_predict(i_req_type, i_letter_first, i_letter_second));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                decipher = i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim_proc
        int key_count;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Before the square is finished: rejected pairs, no-op, key folding
        push_mode(1'b0);
        push_item(REQ_PAIR, 5'd0, 5'd25);
        push_item(REQ_PAIR, 5'd31, LETTER_J);
        push_item(REQ_NONE, 5'd31, 5'd31);
        push_item(REQ_KEY, LETTER_J, 5'd31);
        push_item(REQ_KEY, LETTER_I, 5'd0);
        push_item(REQ_KEY, 5'd31, 5'd21);
        push_item(REQ_KEY, LETTER_LAST, 5'd10);
        push_item(REQ_KEY, 5'd26, 5'd0);
        push_item(REQ_KEY, 5'd0, 5'd31);
        push_drain();

        // Random key letters, duplicates and noise among them
        key_count = $urandom_range(5, 24);
        for (int k = 0; k < key_count; k++) begin
            push_item(REQ_KEY, any_letter(), any_letter());
            if (k == key_count / 2) begin
                push_drain();
            end
        end
        push_item(REQ_NONE, any_letter(), any_letter());
        push_item(REQ_FINISH, any_letter(), any_letter());
        push_item(REQ_FINISH, any_letter(), any_letter());
        push_item(REQ_KEY, any_letter(), any_letter());
        wait_settled();

        // Directed pairs in both modes: row and column wrap, rectangle, same letter
        for (int m = 0; m < 2; m++) begin
            push_mode(m[0]);
            push_cells(0, 4);
            push_cells(21, 24);
            push_cells(2, 22);
            push_cells(5, 0);
            push_cells(6, 18);
            push_cells(12, 12);
            push_item(REQ_PAIR, LETTER_J, 5'd31);
            push_item(REQ_PAIR, 5'd0, LETTER_LAST);
        end

        // Random phases, mode flipped between them
        key_count = $urandom_range(0, 1);
        for (int ph = 0; ph < 8; ph++) begin
            push_mode(ph[0] ^ key_count[0]);
            for (int n = 0; n < 51; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    push_aimed_pair();
                end else begin
                    push_item(t_req'($urandom_range(0, 3)), any_letter(), any_letter());
                end
                if ($urandom_range(0, 99) < 3) begin
                    push_drain();
                end
            end
        end
        wait_settled();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && cipher_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : limit_proc
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- playfair_pair_cipher.f -----
rtl/pf_pkg.sv
rtl/pf_ram.sv
rtl/pf_ctrl.sv
rtl/pf_dpath.sv
rtl/playfair_pair_cipher.sv
verif/tb_playfair_pair_cipher.sv
